FILE: hw/rtl/gbn_pkg.sv
// Package: shared types, constants and codes of the go-back-n sender window.
package gbn_pkg;

    localparam int SEQ_SPACE_DEF  = 20;
    localparam int CNT_W          = 9;   // holds any count up to a 256-entry space
    localparam int ACTION_W       = 2;
    localparam int ACK_W          = 5;
    localparam int CSEQ_W         = 8;
    localparam int SEQ_OUT_W      = 5;
    localparam int PIDX_W         = 16;
    localparam int WIN_W          = 5;
    localparam int TMO_W          = 8;
    localparam int IDLE_W         = 8;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 8;

    localparam logic [WIN_W-1:0]  WINDOW_RESET  = WIN_W'(10);
    localparam logic [TMO_W-1:0]  TIMEOUT_RESET = TMO_W'(20);
    localparam logic [IDLE_W-1:0] IDLE_MAX      = '1;
    localparam logic [PIDX_W-1:0] PIDX_MAX      = '1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_START = 2'd0,
        ACT_SEND  = 2'd1,
        ACT_ACK   = 2'd2,
        ACT_IDLE  = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_SIZE   = 1'b0,
        CFG_TIMEOUT_LIMIT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_dp_cmd;

endpackage

FILE: hw/rtl/gbn_in_if.sv
// Interface: input event channel.
interface gbn_in_if;
    logic                          valid;
    logic                          ready;
    logic [gbn_pkg::ACTION_W-1:0]  action;
    logic [gbn_pkg::ACK_W-1:0]     ack_number;
    logic [gbn_pkg::CSEQ_W-1:0]    client_seq;

    modport source (output valid, output action, output ack_number, output client_seq,
                    input ready);
    modport sink   (input valid, input action, input ack_number, input client_seq,
                    output ready);
endinterface

FILE: hw/rtl/gbn_out_if.sv
// Interface: result channel.
interface gbn_out_if;
    logic                           valid;
    logic                           ready;
    logic                           sent;
    logic [gbn_pkg::SEQ_OUT_W-1:0]  sent_seq;
    logic [gbn_pkg::CSEQ_W-1:0]     piggy_ack;
    logic [gbn_pkg::PIDX_W-1:0]     packet_index;
    logic                           timed_out;
    logic [gbn_pkg::SEQ_OUT_W-1:0]  base_seq;
    logic                           client_in_order;

    modport source (output valid, output sent, output sent_seq, output piggy_ack,
                    output packet_index, output timed_out, output base_seq,
                    output client_in_order, input ready);
    modport sink   (input valid, input sent, input sent_seq, input piggy_ack,
                    input packet_index, input timed_out, input base_seq,
                    input client_in_order, output ready);
endinterface

FILE: hw/rtl/gbn_cfg_if.sv
// Interface: configuration register write channel.
interface gbn_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gbn_pkg::CFG_IDX_W-1:0]   index;
    logic [gbn_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/gbn_ctrl.sv
// Controller: sequencing state machine and result-valid flag.
module gbn_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output gbn_pkg::t_dp_cmd o_cmd
);

    gbn_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            slot_open;

    assign slot_open = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gbn_pkg::ST_IDLE: if (i_in_valid) n_state = gbn_pkg::ST_EXEC;
            gbn_pkg::ST_EXEC: if (slot_open)  n_state = gbn_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            gbn_pkg::ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            gbn_pkg::ST_EXEC: begin
                o_cmd.commit = slot_open;
                if (slot_open) n_out_valid = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gbn_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: hw/rtl/gbn_dp.sv
// Datapath: window state, slot bitmap, configuration and result registers.
module gbn_dp #(
    parameter int SEQ_SPACE = gbn_pkg::SEQ_SPACE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gbn_pkg::t_dp_cmd                i_cmd,
    input  logic [gbn_pkg::ACTION_W-1:0]    i_action,
    input  logic [gbn_pkg::ACK_W-1:0]       i_ack_number,
    input  logic [gbn_pkg::CSEQ_W-1:0]      i_client_seq,
    input  logic                            i_cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                            o_sent,
    output logic [gbn_pkg::SEQ_OUT_W-1:0]   o_sent_seq,
    output logic [gbn_pkg::CSEQ_W-1:0]      o_piggy_ack,
    output logic [gbn_pkg::PIDX_W-1:0]      o_packet_index,
    output logic                            o_timed_out,
    output logic [gbn_pkg::SEQ_OUT_W-1:0]   o_base_seq,
    output logic                            o_client_in_order
);

    localparam int IW = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
    localparam int CW = gbn_pkg::CNT_W;
    localparam logic [CW-1:0] SPACE = CW'(SEQ_SPACE);

    // ring distance (to - from) mod SEQ_SPACE, both operands below SEQ_SPACE
    function automatic logic [CW-1:0] ring_dist(input logic [IW-1:0] to,
                                                input logic [IW-1:0] from);
        logic [CW-1:0] sum;
        sum = CW'(to) + SPACE - CW'(from);
        return (sum >= SPACE) ? sum - SPACE : sum;
    endfunction

    // captured event
    gbn_pkg::t_action                r_action;
    logic [gbn_pkg::ACK_W-1:0]       r_ack;
    logic [gbn_pkg::CSEQ_W-1:0]      r_cseq;

    // configuration
    logic [gbn_pkg::WIN_W-1:0]       r_ws;
    logic [gbn_pkg::TMO_W-1:0]       r_tl;

    // window state
    logic [SEQ_SPACE-1:0]            r_slot_free, n_slot_free;
    logic [IW-1:0]                   r_next, n_next;
    logic [IW-1:0]                   r_base, n_base;
    logic [gbn_pkg::PIDX_W-1:0]      r_pc, n_pc;
    logic [gbn_pkg::CSEQ_W-1:0]      r_exp, n_exp;
    logic [gbn_pkg::CSEQ_W-1:0]      r_last, n_last;
    logic [gbn_pkg::IDLE_W-1:0]      r_idle, n_idle;

    // result values
    logic                            sent, timed_out, in_order;
    logic [gbn_pkg::PIDX_W-1:0]      pidx;

    logic [CW-1:0]                   step;
    logic [CW-1:0]                   ack_cnt, tmo_cnt, free_cnt;
    logic [SEQ_SPACE-1:0]            free_mask;
    logic [IW-1:0]                   ack_idx;
    logic                            ack_ok;
    logic [gbn_pkg::IDLE_W-1:0]      idle_inc;
    logic [CW-1:0]                   next_inc;

    always_comb begin
        step     = ring_dist(r_next, r_base);
        ack_ok   = (r_ack != '0) && (CW'(r_ack) <= SPACE);
        ack_idx  = IW'(CW'(r_ack) - CW'(1));
        ack_cnt  = ring_dist(ack_idx, r_base) + CW'(1);
        tmo_cnt  = (CW'(r_ws) > SPACE) ? SPACE : CW'(r_ws);
        free_cnt = (r_action == gbn_pkg::ACT_ACK) ? ack_cnt : tmo_cnt;
        for (int i = 0; i < SEQ_SPACE; i++) begin
            free_mask[i] = ring_dist(IW'(i), r_base) < free_cnt;
        end
        idle_inc = (r_idle == gbn_pkg::IDLE_MAX) ? r_idle : r_idle + 1'b1;
        next_inc = CW'(r_next) + CW'(1);

        n_slot_free = r_slot_free;
        n_next      = r_next;
        n_base      = r_base;
        n_pc        = r_pc;
        n_exp       = r_exp;
        n_last      = r_last;
        n_idle      = r_idle;
        sent        = 1'b0;
        timed_out   = 1'b0;
        in_order    = 1'b0;

        unique case (r_action)
            gbn_pkg::ACT_START: begin
                n_slot_free = '1;
                n_next      = '0;
                n_base      = '0;
                n_pc        = '0;
                n_exp       = gbn_pkg::CSEQ_W'(1);
                n_last      = '0;
                n_idle      = '0;
            end
            gbn_pkg::ACT_SEND: begin
                if (step < CW'(r_ws) && r_slot_free[r_next]) begin
                    sent                = 1'b1;
                    n_slot_free[r_next] = 1'b0;
                    n_next              = (next_inc >= SPACE) ? '0 : IW'(next_inc);
                end
            end
            gbn_pkg::ACT_ACK: begin
                if (r_cseq == r_exp) begin
                    in_order = 1'b1;
                    n_last   = r_cseq;
                    n_exp    = (CW'(r_exp) + CW'(1) >= SPACE) ? gbn_pkg::CSEQ_W'(1)
                                                              : r_exp + 1'b1;
                end
                if (ack_ok) begin
                    n_slot_free = r_slot_free | free_mask;
                    n_base      = (CW'(r_ack) >= SPACE) ? '0 : IW'(r_ack);
                end
            end
            gbn_pkg::ACT_IDLE: begin
                n_idle = idle_inc;
                if (idle_inc > r_tl) begin
                    timed_out   = 1'b1;
                    n_slot_free = r_slot_free | free_mask;
                    n_pc        = (gbn_pkg::PIDX_W'(step) < r_pc)
                                  ? r_pc - gbn_pkg::PIDX_W'(step) : '0;
                    n_next      = r_base;
                    n_idle      = '0;
                end
            end
        endcase

        pidx = n_pc;
        if (sent) begin
            pidx = r_pc;
            if (r_pc != gbn_pkg::PIDX_MAX) n_pc = r_pc + 1'b1;
        end
    end

    // event capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= gbn_pkg::t_action'(i_action);
            r_ack    <= i_ack_number;
            r_cseq   <= i_client_seq;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws <= gbn_pkg::WINDOW_RESET;
            r_tl <= gbn_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (gbn_pkg::t_cfg_idx'(i_cfg_index))
                gbn_pkg::CFG_WINDOW_SIZE:   r_ws <= gbn_pkg::WIN_W'(i_cfg_data);
                gbn_pkg::CFG_TIMEOUT_LIMIT: r_tl <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_free <= '1;
            r_next      <= '0;
            r_base      <= '0;
            r_pc        <= '0;
            r_exp       <= gbn_pkg::CSEQ_W'(1);
            r_last      <= '0;
            r_idle      <= '0;
        end else if (i_cmd.commit) begin
            r_slot_free <= n_slot_free;
            r_next      <= n_next;
            r_base      <= n_base;
            r_pc        <= n_pc;
            r_exp       <= n_exp;
            r_last      <= n_last;
            r_idle      <= n_idle;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_sent            <= sent;
            o_sent_seq        <= sent ? gbn_pkg::SEQ_OUT_W'(next_inc) : '0;
            o_piggy_ack       <= n_last;
            o_packet_index    <= pidx;
            o_timed_out       <= timed_out;
            o_base_seq        <= gbn_pkg::SEQ_OUT_W'(CW'(n_base));
            o_client_in_order <= in_order;
        end
    end

endmodule

FILE: hw/rtl/go_back_n_sender_window.sv
// Top level: go-back-n sender window, controller plus datapath.
//
//   channel   dir   handshake            payload
//   i_in      in    valid / ready        action, ack_number, client_seq
//   o_out     out   valid / ready        sent, sent_seq, piggy_ack, packet_index,
//                                        timed_out, base_seq, client_in_order
//   i_cfg     in    valid / ready        index (0 window_size, 1 timeout_limit), data
//
// Each event is captured in the idle state; in the execute state the window
// state is updated and the result register loaded, the state update being
// combinational slot-bitmap logic. The next event is taken while a result
// waits to be read. A result not yet taken holds the execute state until the
// result register frees. Synchronous active-low reset restores the window and
// the configuration defaults; the configuration port is always ready.
module go_back_n_sender_window #(
    parameter int SEQ_SPACE = gbn_pkg::SEQ_SPACE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gbn_in_if.sink    i_in,
    gbn_out_if.source o_out,
    gbn_cfg_if.sink   i_cfg
);

    gbn_pkg::t_dp_cmd cmd;

    // accept configuration writes at any time
    assign i_cfg.ready = 1'b1;

    gbn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    gbn_dp #(
        .SEQ_SPACE (SEQ_SPACE)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_action          (i_in.action),
        .i_ack_number      (i_in.ack_number),
        .i_client_seq      (i_in.client_seq),
        .i_cfg_we          (i_cfg.valid),
        .i_cfg_index       (i_cfg.index),
        .i_cfg_data        (i_cfg.data),
        .o_sent            (o_out.sent),
        .o_sent_seq        (o_out.sent_seq),
        .o_piggy_ack       (o_out.piggy_ack),
        .o_packet_index    (o_out.packet_index),
        .o_timed_out       (o_out.timed_out),
        .o_base_seq        (o_out.base_seq),
        .o_client_in_order (o_out.client_in_order)
    );

endmodule
